/* rtl/core/bsc_pkg.sv */
// Shared types and constants for the barometric second-order compensation pipeline.
`default_nettype none

package bsc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CAL_W     = 16;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE           = 3'd5;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;
  localparam logic signed [19:0] TEMP_LOW = -20'sd1500;

  // 32-bit pressure bounds, sign-extended to 33 bits
  localparam logic signed [32:0] P_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] P_MIN = 33'sh1_8000_0000;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // Temperature front end result
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] temp1;
    logic signed [18:0] temp2;
    logic signed [39:0] off_base;
    logic signed [39:0] sens_base;
    logic [33:0]        dsq;
    logic [33:0]        esq;
    logic               lt_ref;
    logic               lt_low;
  } temp_item_t;

  // Corrected offset and sensitivity
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] temp1;
    logic signed [18:0] temp2;
    logic signed [39:0] off;
    logic signed [39:0] sens;
  } corr_item_t;

endpackage

`default_nettype wire

/* rtl/core/bsc_temp.sv */
// Temperature difference, first and second order temperature, base offset and sensitivity.
`default_nettype none

module bsc_temp
  import bsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cal_t       cal,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [23:0] in_d1,
  input  wire logic [23:0] in_d2,
  output logic            out_valid,
  input  wire logic       out_stall,
  output temp_item_t      out_item
);

  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // Stage A: temperature difference
  logic [23:0]        d1_a_r;
  logic signed [24:0] dt_a_r;
  logic signed [24:0] dt_a_nxt;

  // Stage B: products of dT
  logic [23:0]        d1_b_r;
  logic signed [41:0] p6_b_r, p4_b_r, p3_b_r;
  logic signed [49:0] pt_b_r;
  logic signed [41:0] p6_b_nxt, p4_b_nxt, p3_b_nxt;
  logic signed [49:0] pt_b_nxt;

  // Stage C: first-order temperature, base offset and sensitivity
  logic [23:0]        d1_c_r;
  logic signed [18:0] temp1_c_r;
  logic signed [39:0] off_c_r, sens_c_r;
  logic [17:0]        dtsh_c_r;
  logic signed [19:0] temp1_c_nxt;
  logic signed [34:0] offt_c;
  logic signed [33:0] senst_c;
  logic signed [39:0] off_c_nxt, sens_c_nxt;

  // Stage D: squares for second-order correction
  temp_item_t         item_d_r;
  temp_item_t         item_d_nxt;
  logic signed [19:0] t1_d;
  logic signed [19:0] dd_d, de_d;
  logic signed [39:0] dsq_d, esq_d;
  logic signed [19:0] t2_d;

  assign rdy_d    = !vld_d_r || !out_stall;
  assign rdy_c    = !vld_c_r || rdy_d;
  assign rdy_b    = !vld_b_r || rdy_c;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign in_stall = !rdy_a;

  always_comb begin
    dt_a_nxt = $signed({1'b0, in_d2}) - $signed({1'b0, cal.c5, 8'h00});
  end

  always_comb begin
    p6_b_nxt = dt_a_r * $signed({1'b0, cal.c6});
    p4_b_nxt = dt_a_r * $signed({1'b0, cal.c4});
    p3_b_nxt = dt_a_r * $signed({1'b0, cal.c3});
    pt_b_nxt = dt_a_r * dt_a_r;
  end

  always_comb begin
    temp1_c_nxt = $signed({p6_b_r[41], p6_b_r[41:23]}) + TEMP_REF;
    offt_c      = p4_b_r[41:7];
    senst_c     = p3_b_r[41:8];
    off_c_nxt   = $signed({8'h00, cal.c2, 16'h0000}) + $signed({{5{offt_c[34]}}, offt_c});
    sens_c_nxt  = $signed({9'h000, cal.c1, 15'h0000}) + $signed({{6{senst_c[33]}}, senst_c});
  end

  always_comb begin
    t1_d  = $signed({temp1_c_r[18], temp1_c_r});
    dd_d  = t1_d - TEMP_REF;
    de_d  = t1_d - TEMP_LOW;
    dsq_d = dd_d * dd_d;
    esq_d = de_d * de_d;
    t2_d  = t1_d - $signed({2'b00, dtsh_c_r});
    item_d_nxt.d1        = d1_c_r;
    item_d_nxt.temp1     = temp1_c_r;
    item_d_nxt.lt_ref    = t1_d < TEMP_REF;
    item_d_nxt.lt_low    = t1_d < TEMP_LOW;
    item_d_nxt.temp2     = item_d_nxt.lt_ref ? t2_d[18:0] : temp1_c_r;
    item_d_nxt.off_base  = off_c_r;
    item_d_nxt.sens_base = sens_c_r;
    item_d_nxt.dsq       = dsq_d[33:0];
    item_d_nxt.esq       = esq_d[33:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= in_valid;
      if (rdy_b) vld_b_r <= vld_a_r;
      if (rdy_c) vld_c_r <= vld_b_r;
      if (rdy_d) vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      d1_a_r <= in_d1;
      dt_a_r <= dt_a_nxt;
    end
    if (rdy_b) begin
      d1_b_r <= d1_a_r;
      p6_b_r <= p6_b_nxt;
      p4_b_r <= p4_b_nxt;
      p3_b_r <= p3_b_nxt;
      pt_b_r <= pt_b_nxt;
    end
    if (rdy_c) begin
      d1_c_r    <= d1_b_r;
      temp1_c_r <= temp1_c_nxt[18:0];
      off_c_r   <= off_c_nxt;
      sens_c_r  <= sens_c_nxt;
      dtsh_c_r  <= pt_b_r[48:31];
    end
    if (rdy_d) begin
      item_d_r <= item_d_nxt;
    end
  end

  assign out_valid = vld_d_r;
  assign out_item  = item_d_r;

endmodule

`default_nettype wire

/* rtl/core/bsc_corr.sv */
// Second-order correction of offset and sensitivity.
`default_nettype none

module bsc_corr
  import bsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_stall,
  input  wire temp_item_t in_item,
  output logic            dn_valid,
  input  wire logic       dn_stall,
  output corr_item_t      out_item
);

  logic vld_e_r, vld_f_r;
  logic rdy_e, rdy_f;

  // Stage E: correction terms
  logic [23:0]        d1_e_r;
  logic signed [18:0] temp1_e_r, temp2_e_r;
  logic signed [39:0] off_e_r, sens_e_r;
  logic [37:0]        offc_e_r, sensc_e_r;
  logic [36:0]        five_d, seven_e;
  logic [37:0]        eleven_e;
  logic [37:0]        offc_e_nxt, sensc_e_nxt;

  // Stage F: corrected values
  corr_item_t         item_f_r;
  corr_item_t         item_f_nxt;

  assign rdy_f    = !vld_f_r || !dn_stall;
  assign rdy_e    = !vld_e_r || rdy_f;
  assign up_stall = !rdy_e;

  always_comb begin
    five_d   = {1'b0, in_item.dsq, 2'b00} + {3'b000, in_item.dsq};
    seven_e  = {in_item.esq, 3'b000} - {3'b000, in_item.esq};
    eleven_e = {1'b0, in_item.esq, 3'b000} + {3'b000, in_item.esq, 1'b0}
             + {4'h0, in_item.esq};
    offc_e_nxt  = '0;
    sensc_e_nxt = '0;
    if (in_item.lt_ref) begin
      offc_e_nxt  = {2'b00, five_d[36:1]};
      sensc_e_nxt = {3'b000, five_d[36:2]};
      if (in_item.lt_low) begin
        offc_e_nxt  = offc_e_nxt + {1'b0, seven_e};
        sensc_e_nxt = sensc_e_nxt + {1'b0, eleven_e[37:1]};
      end
    end
  end

  always_comb begin
    item_f_nxt.d1    = d1_e_r;
    item_f_nxt.temp1 = temp1_e_r;
    item_f_nxt.temp2 = temp2_e_r;
    item_f_nxt.off   = off_e_r - $signed({2'b00, offc_e_r});
    item_f_nxt.sens  = sens_e_r - $signed({2'b00, sensc_e_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
    end else begin
      if (rdy_e) vld_e_r <= up_valid;
      if (rdy_f) vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      d1_e_r    <= in_item.d1;
      temp1_e_r <= in_item.temp1;
      temp2_e_r <= in_item.temp2;
      off_e_r   <= in_item.off_base;
      sens_e_r  <= in_item.sens_base;
      offc_e_r  <= offc_e_nxt;
      sensc_e_r <= sensc_e_nxt;
    end
    if (rdy_f) begin
      item_f_r <= item_f_nxt;
    end
  end

  assign dn_valid = vld_f_r;
  assign out_item = item_f_r;

endmodule

`default_nettype wire

/* rtl/core/bsc_press.sv */
// Compensated pressure: split 64-bit product, shifts, offset and saturation.
`default_nettype none

module bsc_press
  import bsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_stall,
  input  wire corr_item_t in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [18:0]     out_temp1,
  output logic [18:0]     out_temp2,
  output logic [31:0]     out_pressure,
  output logic            out_clipped
);

  logic vld_g_r, vld_h_r, vld_i_r;
  logic rdy_g, rdy_h, rdy_i;

  // Stage G: partial products of D1 and sensitivity
  logic signed [18:0] temp1_g_r, temp2_g_r;
  logic signed [39:0] off_g_r;
  logic [43:0]        pl_g_r;
  logic signed [44:0] ph_g_r;
  logic [43:0]        pl_g_nxt;
  logic signed [44:0] ph_g_nxt;

  // Stage H: full product
  logic signed [18:0] temp1_h_r, temp2_h_r;
  logic signed [39:0] off_h_r;
  logic signed [63:0] prod_h_r;
  logic signed [64:0] prod_h_sum;

  // Stage I: pressure and clamp
  logic [18:0]        temp1_i_r, temp2_i_r;
  logic [31:0]        press_i_r;
  logic               clip_i_r;
  logic signed [42:0] q_i;
  logic signed [43:0] r_i;
  logic signed [32:0] pext_i;
  logic [31:0]        press_i_nxt;
  logic               clip_i_nxt;

  assign rdy_i    = !vld_i_r || !out_stall;
  assign rdy_h    = !vld_h_r || rdy_i;
  assign rdy_g    = !vld_g_r || rdy_h;
  assign up_stall = !rdy_g;

  always_comb begin
    pl_g_nxt = in_item.d1 * in_item.sens[19:0];
    ph_g_nxt = $signed({1'b0, in_item.d1}) * $signed(in_item.sens[39:20]);
  end

  always_comb begin
    prod_h_sum = $signed({ph_g_r, 20'h00000}) + $signed({21'h000000, pl_g_r});
  end

  always_comb begin
    q_i    = prod_h_r[63:21];
    r_i    = $signed({q_i[42], q_i}) - $signed({{4{off_h_r[39]}}, off_h_r});
    pext_i = $signed({{4{r_i[43]}}, r_i[43:15]});
    // Saturate to the 32-bit range
    if (pext_i > P_MAX) begin
      press_i_nxt = P_MAX[31:0];
      clip_i_nxt  = 1'b1;
    end else if (pext_i < P_MIN) begin
      press_i_nxt = P_MIN[31:0];
      clip_i_nxt  = 1'b1;
    end else begin
      press_i_nxt = pext_i[31:0];
      clip_i_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_g_r <= 1'b0;
      vld_h_r <= 1'b0;
      vld_i_r <= 1'b0;
    end else begin
      if (rdy_g) vld_g_r <= up_valid;
      if (rdy_h) vld_h_r <= vld_g_r;
      if (rdy_i) vld_i_r <= vld_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_g) begin
      temp1_g_r <= in_item.temp1;
      temp2_g_r <= in_item.temp2;
      off_g_r   <= in_item.off;
      pl_g_r    <= pl_g_nxt;
      ph_g_r    <= ph_g_nxt;
    end
    if (rdy_h) begin
      temp1_h_r <= temp1_g_r;
      temp2_h_r <= temp2_g_r;
      off_h_r   <= off_g_r;
      prod_h_r  <= prod_h_sum[63:0];
    end
    if (rdy_i) begin
      temp1_i_r <= temp1_h_r;
      temp2_i_r <= temp2_h_r;
      press_i_r <= press_i_nxt;
      clip_i_r  <= clip_i_nxt;
    end
  end

  assign out_valid    = vld_i_r;
  assign out_temp1    = temp1_i_r;
  assign out_temp2    = temp2_i_r;
  assign out_pressure = press_i_r;
  assign out_clipped  = clip_i_r;

endmodule

`default_nettype wire

/* rtl/core/baro_second_order_compensation.sv */
// Top level: calibration registers and the three pipeline sections.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_press_adc, in_temp_adc
//   out_     output     out_valid / out_stall out_temp_first_order, out_temp_corrected,
//                                             out_pressure, out_pressure_clipped
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle while out_stall is low; four temperature stages, two
// correction stages, three pressure stages with the 24x40 product split in two.
// rst_n is synchronous; it clears the calibration words and all valid bits.
// Each stage holds while the next one is full and stalled; empty stages
// still fill, so input is taken while a result waits at the output.
`default_nettype none

module baro_second_order_compensation
  import bsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [23:0]          in_press_adc,
  input  wire logic [23:0]          in_temp_adc,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [18:0]        out_temp_first_order,
  output logic signed [18:0]        out_temp_corrected,
  output logic signed [31:0]        out_pressure,
  output logic                      out_pressure_clipped
);

  cal_t       cal_r;
  cal_t       cal_nxt;
  logic       tc_valid, cp_valid;
  logic       tc_stall, cp_stall;
  temp_item_t tc_item;
  corr_item_t cp_item;
  logic [18:0] t1_out, t2_out;
  logic [31:0] p_out;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PRESSURE_SENSITIVITY: cal_nxt.c1 = cfg_wdata;
        REG_PRESSURE_OFFSET:      cal_nxt.c2 = cfg_wdata;
        REG_SENS_TEMP_COEFF:      cal_nxt.c3 = cfg_wdata;
        REG_OFFSET_TEMP_COEFF:    cal_nxt.c4 = cfg_wdata;
        REG_REFERENCE_TEMP:       cal_nxt.c5 = cfg_wdata;
        REG_TEMP_SLOPE:           cal_nxt.c6 = cfg_wdata;
        default:                  cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  bsc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_d1     (in_press_adc),
    .in_d2     (in_temp_adc),
    .out_valid (tc_valid),
    .out_stall (tc_stall),
    .out_item  (tc_item)
  );

  bsc_corr u_corr (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (tc_valid),
    .up_stall (tc_stall),
    .in_item  (tc_item),
    .dn_valid (cp_valid),
    .dn_stall (cp_stall),
    .out_item (cp_item)
  );

  bsc_press u_press (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (cp_valid),
    .up_stall     (cp_stall),
    .in_item      (cp_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_temp1    (t1_out),
    .out_temp2    (t2_out),
    .out_pressure (p_out),
    .out_clipped  (out_pressure_clipped)
  );

  assign out_temp_first_order = $signed(t1_out);
  assign out_temp_corrected   = $signed(t2_out);
  assign out_pressure         = $signed(p_out);

  // Correction only ever lowers the temperature
  a_temp_not_raised: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_corrected <= out_temp_first_order)
    else $error("corrected temperature above first-order temperature");

  // No second-order term at or above the reference temperature
  a_warm_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_temp_first_order >= 19'sd2000 |->
      out_temp_corrected == out_temp_first_order)
    else $error("temperature corrected above reference");

  // A clipped pressure sits on a bound
  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_clipped |->
      (out_pressure == 32'sh7FFF_FFFF || out_pressure == -32'sh8000_0000))
    else $error("clipped pressure not at a bound");

  // Calibration words change only through a write
  a_cal_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) && $past(rst_n) |-> $stable(cal_r))
    else $error("calibration changed without a write");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the barometric second-order compensation pipeline.
`default_nettype none

module testbench;
  import bsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 85;

  typedef struct packed {
    logic [23:0] press_adc;
    logic [23:0] temp_adc;
  } raw_sample_t;

  typedef struct packed {
    logic signed [18:0] temp_first_order;
    logic signed [18:0] temp_corrected;
    logic signed [31:0] pressure;
    logic               pressure_clipped;
  } reading_t;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [23:0]          in_press_adc = '0;
  logic [23:0]          in_temp_adc = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [18:0]   out_temp_first_order;
  logic signed [18:0]   out_temp_corrected;
  logic signed [31:0]   out_pressure;
  logic                 out_pressure_clipped;

  baro_second_order_compensation uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_press_adc         (in_press_adc),
    .in_temp_adc          (in_temp_adc),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_temp_first_order (out_temp_first_order),
    .out_temp_corrected   (out_temp_corrected),
    .out_pressure         (out_pressure),
    .out_pressure_clipped (out_pressure_clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Calibration copy kept in step with every register write
  logic [CAL_W-1:0] cal_word [0:5] = '{default: '0};

  raw_sample_t raw_samples[$];
  reading_t    compensated_due[$];

  int error_count = 0;
  int checked_count = 0;
  int setting_count = 0;
  int warm_count = 0;
  int cold_count = 0;
  int frigid_count = 0;
  int clipped_count = 0;

  function automatic reading_t compensate(input logic [23:0] d1, input logic [23:0] d2);
    longint   p_raw, t_raw, c1, c2, c3, c4, c5, c6;
    longint   dt, t1, t2, off, sens, sq, p;
    reading_t r;
    p_raw = d1;
    t_raw = d2;
    c1 = cal_word[REG_PRESSURE_SENSITIVITY];
    c2 = cal_word[REG_PRESSURE_OFFSET];
    c3 = cal_word[REG_SENS_TEMP_COEFF];
    c4 = cal_word[REG_OFFSET_TEMP_COEFF];
    c5 = cal_word[REG_REFERENCE_TEMP];
    c6 = cal_word[REG_TEMP_SLOPE];
    dt   = t_raw - c5 * 256;
    t1   = TEMP_REF + ((dt * c6) >>> 23);
    t2   = t1;
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    if (t1 < TEMP_REF) begin
      sq   = t1 - TEMP_REF;
      sq   = 5 * sq * sq;
      off  = off - (sq >>> 1);
      sens = sens - (sq >>> 2);
      // extra term in the very cold range
      if (t1 < TEMP_LOW) begin
        sq   = t1 - TEMP_LOW;
        sq   = sq * sq;
        off  = off - 7 * sq;
        sens = sens - ((11 * sq) >>> 1);
      end
      t2 = t1 - ((dt * dt) >>> 31);
    end
    p = (((p_raw * sens) >>> 21) - off) >>> 15;
    r.pressure_clipped = 1'b0;
    if (p > P_MAX) begin
      p = P_MAX;
      r.pressure_clipped = 1'b1;
    end else if (p < P_MIN) begin
      p = P_MIN;
      r.pressure_clipped = 1'b1;
    end
    r.temp_first_order = t1[18:0];
    r.temp_corrected   = t2[18:0];
    r.pressure         = p[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch on result %0d, %s: got %0d, want %0d", checked_count, what, got, want);
  endtask

  // Sender: bursts of random length, most of them followed by a random gap
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : sender
    raw_sample_t next_sample;
    reading_t    predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = compensate(in_press_adc, in_temp_adc);
        compensated_due.push_back(predicted);
        if (predicted.temp_first_order < TEMP_LOW) frigid_count++;
        else if (predicted.temp_first_order < TEMP_REF) cold_count++;
        else warm_count++;
        if (predicted.pressure_clipped) clipped_count++;
      end
      // hold a stalled item; otherwise pick the next step
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raw_samples.size() > 0) begin
          next_sample = raw_samples.pop_front();
          in_valid     <= 1'b1;
          in_press_adc <= next_sample.press_adc;
          in_temp_adc  <= next_sample.temp_adc;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(30, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 5);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that switches mode every so often
  rx_mode_t stall_mode = RX_STREAM;
  int       stall_timer = 0;

  always @(posedge clk) begin : receiver
    if (stall_timer == 0) begin
      stall_mode  <= rx_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(20, 120);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      RX_STREAM:   out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall <= (stall_timer[2:0] < 3'd3);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (compensated_due.size() == 0) begin
        report_mismatch("result with nothing pending", out_pressure, 0);
      end else begin
        want = compensated_due.pop_front();
        if (out_temp_first_order !== want.temp_first_order)
          report_mismatch("temp_first_order", out_temp_first_order, want.temp_first_order);
        if (out_temp_corrected !== want.temp_corrected)
          report_mismatch("temp_corrected", out_temp_corrected, want.temp_corrected);
        if (out_pressure !== want.pressure)
          report_mismatch("pressure", out_pressure, want.pressure);
        if (out_pressure_clipped !== want.pressure_clipped)
          report_mismatch("pressure_clipped", out_pressure_clipped, want.pressure_clipped);
      end
    end
  end

  task automatic queue_sample(input logic [23:0] d1, input logic [23:0] d2);
    raw_sample_t s;
    s.press_adc = d1;
    s.temp_adc  = d2;
    raw_samples.push_back(s);
  endtask

  // Wait until every queued item went in and every result came out
  task automatic wait_drained();
    @(negedge clk);
    while (raw_samples.size() != 0 || in_valid || compensated_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx <= REG_TEMP_SLOPE)
      cal_word[idx] = value;
  endtask

  task automatic load_cal(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                          input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                          input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
    write_reg(REG_PRESSURE_SENSITIVITY, c1);
    write_reg(REG_PRESSURE_OFFSET, c2);
    write_reg(REG_SENS_TEMP_COEFF, c3);
    write_reg(REG_OFFSET_TEMP_COEFF, c4);
    write_reg(REG_REFERENCE_TEMP, c5);
    write_reg(REG_TEMP_SLOPE, c6);
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin : stimulus
    logic [CAL_W-1:0] w [0:5];
    longint           d2_near;
    logic [23:0]      d1, d2;
    int               pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // calibration words still at their reset value
    queue_sample(24'h000000, 24'h000000);
    queue_sample(24'hFFFFFF, 24'hFFFFFF);
    wait_drained();

    // typical factory words
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    queue_sample(24'd9085466, 24'd8569150);
    queue_sample(24'hFFFFFF, 24'h000000);
    queue_sample(24'h000000, 24'hFFFFFF);
    wait_drained();

    // reference at 2^23 and unit slope: thresholds fall on exact readings
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768);
    // writes past the last register must change nothing
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_sample(24'hAAAAAA, 24'h800000);
    queue_sample(24'h555555, 24'h7FFFFF);
    queue_sample(24'd9085466, 24'd7492608);
    queue_sample(24'h000000, 24'd7492607);
    queue_sample(24'hFFFFFF, 24'h800001);
    queue_sample(24'd4000000, 24'd7000000);
    wait_drained();

    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_sample(24'hFFFFFF, 24'hFFFFFF);
    queue_sample(24'hFFFFFF, 24'h000000);
    queue_sample(24'h000000, 24'h000000);
    wait_drained();

    load_cal(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    queue_sample(24'hFFFFFF, 24'hFFFFFF);
    queue_sample(24'hFFFFFF, 24'h000000);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int k = 0; k < 6; k++) begin
        pick = $urandom_range(0, 7);
        w[k] = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      end
      load_cal(w[0], w[1], w[2], w[3], w[4], w[5]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 7);
        d1 = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
        pick = $urandom_range(0, 7);
        if (pick < 4) begin
          // land near the reference so all three temperature ranges show up
          d2_near = longint'(w[4]) * 256 + longint'($urandom_range(0, 2000000)) - 1000000;
          if (d2_near < 0) d2_near = 0;
          if (d2_near > 24'hFFFFFF) d2_near = 24'hFFFFFF;
          d2 = d2_near[23:0];
        end else if (pick == 4) begin
          d2 = 24'h000000;
        end else if (pick == 5) begin
          d2 = 24'hFFFFFF;
        end else begin
          d2 = 24'($urandom);
        end
        queue_sample(d1, d2);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results over %0d calibration settings", checked_count, setting_count);
    $display("warm %0d, cold %0d, below -15.00 %0d, clipped %0d, mismatches %0d",
             warm_count, cold_count, frigid_count, clipped_count, error_count);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/bsc_pkg.sv
rtl/core/bsc_temp.sv
rtl/core/bsc_corr.sv
rtl/core/bsc_press.sv
rtl/core/baro_second_order_compensation.sv
sim/testbench.sv
